@@ rtl/core/drfs_pkg.sv @@
// Package with shared types, constants and helper functions of the record field splitter.
package drfs_pkg;

    localparam int MAX_FIELDS = 8;
    localparam int MAX_SEP_CHARS = 4;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] DISCARD_TARGET = 8'hFF;

    localparam logic [2:0] CFG_FIELD_SEP_CHARS = 3'd0;
    localparam logic [2:0] CFG_FIELD_SEP_COUNT = 3'd1;
    localparam logic [2:0] CFG_RECORD_SEP_CHARS = 3'd2;
    localparam logic [2:0] CFG_RECORD_SEP_COUNT = 3'd3;
    localparam logic [2:0] CFG_DEFINED_FIELD_COUNT = 3'd4;
    localparam logic [2:0] CFG_FIELD_TARGET_MAP = 3'd5;

    typedef enum logic [1:0] {
        KIND_FIELD_BYTE = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_RECORD_END = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_COLLECT = 2'd0,
        MODE_DROP = 2'd1,
        MODE_SKIP = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind kind;
        logic [7:0] target;
    } t_slot;

    typedef struct packed {
        t_slot [MAX_RESULTS-1:0] slots;
        logic [1:0] last;
        logic [7:0] data_byte;
        logic [31:0] line;
        logic [3:0] seen;
    } t_entry;

    function automatic logic sep_match(input logic [7:0] b, input logic [31:0] chars,
                                       input logic [2:0] count);
        logic [2:0] lim;
        logic hit;
        lim = (count > 3'(MAX_SEP_CHARS)) ? 3'(MAX_SEP_CHARS) : count;
        hit = 1'b0;
        for (int k = 0; k < MAX_SEP_CHARS; k++) begin
            if ((3'(k) < lim) && (chars[8*k +: 8] == b)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [3:0] field_limit(input logic [3:0] n);
        logic [3:0] lim;
        lim = n;
        if (lim == 4'd0) begin
            lim = 4'd1;
        end
        if (lim > 4'(MAX_FIELDS)) begin
            lim = 4'(MAX_FIELDS);
        end
        return lim;
    endfunction

    function automatic logic [7:0] target_of(input logic [63:0] map, input logic [3:0] pos);
        return map[8*pos[2:0] +: 8];
    endfunction

endpackage

@@ rtl/core/drfs_if.sv @@
// Interfaces of the input, output and configuration channels of the record field splitter.
interface drfs_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic end_of_buffer;
    modport source(output valid, output data_byte, output end_of_buffer, input ready);
    modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface drfs_out_if;
    logic valid;
    logic ready;
    logic [1:0] result_kind;
    logic [7:0] target_index;
    logic [7:0] field_byte;
    logic [31:0] line_number;
    logic [3:0] fields_seen;
    logic last_of_run;
    modport source(output valid, output result_kind, output target_index, output field_byte,
                   output line_number, output fields_seen, output last_of_run, input ready);
    modport sink(input valid, input result_kind, input target_index, input field_byte,
                 input line_number, input fields_seen, input last_of_run, output ready);
endinterface

interface drfs_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [63:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/core/drfs_front.sv @@
// Front end: configuration registers, byte classification, parse state update and result bundle assembly.
module drfs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    drfs_in_if.sink            i_in,
    drfs_cfg_if.sink           i_cfg,
    input  logic               i_full,
    output logic               o_push,
    output drfs_pkg::t_entry   o_push_data
);

    logic [31:0] r_fs_chars;
    logic [2:0]  r_fs_count;
    logic [31:0] r_rs_chars;
    logic [2:0]  r_rs_count;
    logic [3:0]  r_field_count;
    logic [63:0] r_map;

    drfs_pkg::t_mode r_mode;
    drfs_pkg::t_mode n_mode;
    logic [3:0]  r_pos;
    logic [3:0]  n_pos;
    logic [31:0] r_cnt;
    logic [31:0] n_cnt;

    logic w_accept;
    logic w_fs;
    logic w_rs;
    logic w_collect;
    logic w_close1;
    logic w_end1;
    logic w_emit_byte;
    logic w_close2;
    drfs_pkg::t_mode w_mode_a;
    drfs_pkg::t_mode w_mode_b;
    logic [3:0] w_p1;
    logic [3:0] w_pos_b;
    logic [7:0] w_t0;
    logic [7:0] w_t2;
    logic [1:0] w_n;

    assign i_in.ready = !i_full;
    assign w_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_chars <= 32'd44;
            r_fs_count <= 3'd1;
            r_rs_chars <= 32'd10;
            r_rs_count <= 3'd1;
            r_field_count <= 4'd1;
            r_map <= '1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                drfs_pkg::CFG_FIELD_SEP_CHARS: begin
                    r_fs_chars <= i_cfg.data[31:0];
                end
                drfs_pkg::CFG_FIELD_SEP_COUNT: begin
                    r_fs_count <= i_cfg.data[2:0];
                end
                drfs_pkg::CFG_RECORD_SEP_CHARS: begin
                    r_rs_chars <= i_cfg.data[31:0];
                end
                drfs_pkg::CFG_RECORD_SEP_COUNT: begin
                    r_rs_count <= i_cfg.data[2:0];
                end
                drfs_pkg::CFG_DEFINED_FIELD_COUNT: begin
                    r_field_count <= i_cfg.data[3:0];
                end
                drfs_pkg::CFG_FIELD_TARGET_MAP: begin
                    r_map <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin : classify
        w_fs = drfs_pkg::sep_match(i_in.data_byte, r_fs_chars, r_fs_count);
        w_rs = !w_fs && drfs_pkg::sep_match(i_in.data_byte, r_rs_chars, r_rs_count);
        case (r_mode)
            drfs_pkg::MODE_SKIP: begin
                w_collect = !w_rs;
                w_mode_a = w_rs ? drfs_pkg::MODE_SKIP : drfs_pkg::MODE_COLLECT;
            end
            drfs_pkg::MODE_DROP: begin
                w_collect = 1'b0;
                w_mode_a = w_rs ? drfs_pkg::MODE_SKIP : drfs_pkg::MODE_DROP;
            end
            default: begin
                w_collect = 1'b1;
                w_mode_a = drfs_pkg::MODE_COLLECT;
            end
        endcase
        w_t0 = drfs_pkg::target_of(r_map, r_pos);
        w_p1 = r_pos + 4'd1;
        w_close1 = w_collect && (w_fs || w_rs);
        w_end1 = w_collect &&
                 (w_rs || (w_fs && (w_p1 >= drfs_pkg::field_limit(r_field_count))));
        w_emit_byte = w_collect && !w_fs && !w_rs && (w_t0 != drfs_pkg::DISCARD_TARGET);
        w_mode_b = w_mode_a;
        if (w_end1) begin
            w_mode_b = w_rs ? drfs_pkg::MODE_SKIP : drfs_pkg::MODE_DROP;
        end
        w_pos_b = w_end1 ? 4'd0 : (w_close1 ? w_p1 : r_pos);
        w_close2 = i_in.end_of_buffer && (w_mode_b == drfs_pkg::MODE_COLLECT);
        w_t2 = drfs_pkg::target_of(r_map, w_pos_b);
    end

    always_comb begin : next_state
        n_mode = r_mode;
        n_pos = r_pos;
        n_cnt = r_cnt;
        if (w_accept) begin
            if (i_in.end_of_buffer) begin
                n_mode = drfs_pkg::MODE_COLLECT;
                n_pos = 4'd0;
                n_cnt = 32'd0;
            end else begin
                n_mode = w_mode_b;
                n_pos = w_pos_b;
                n_cnt = r_cnt + {31'd0, w_end1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= drfs_pkg::MODE_COLLECT;
            r_pos <= 4'd0;
            r_cnt <= 32'd0;
        end else begin
            r_mode <= n_mode;
            r_pos <= n_pos;
            r_cnt <= n_cnt;
        end
    end

    always_comb begin : build_entry
        o_push_data = '0;
        w_n = 2'd0;
        if (w_emit_byte) begin
            o_push_data.slots[w_n] = {drfs_pkg::KIND_FIELD_BYTE, w_t0};
            w_n = w_n + 2'd1;
        end
        if (w_close1 && (w_t0 != drfs_pkg::DISCARD_TARGET)) begin
            o_push_data.slots[w_n] = {drfs_pkg::KIND_FIELD_END, w_t0};
            w_n = w_n + 2'd1;
        end
        if (w_end1) begin
            o_push_data.slots[w_n] = {drfs_pkg::KIND_RECORD_END, 8'd0};
            w_n = w_n + 2'd1;
        end
        if (w_close2 && (w_t2 != drfs_pkg::DISCARD_TARGET)) begin
            o_push_data.slots[w_n] = {drfs_pkg::KIND_FIELD_END, w_t2};
            w_n = w_n + 2'd1;
        end
        if (w_close2) begin
            o_push_data.slots[w_n] = {drfs_pkg::KIND_RECORD_END, 8'd0};
            w_n = w_n + 2'd1;
        end
        o_push_data.last = w_n - 2'd1;
        o_push_data.data_byte = i_in.data_byte;
        o_push_data.line = r_cnt + 32'd1;
        o_push_data.seen = w_end1 ? w_p1 : (w_pos_b + 4'd1);
        o_push = w_accept && (w_n != 2'd0);
    end

`ifndef SYNTHESIS
    a_eob_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.end_of_buffer |=>
        r_mode == drfs_pkg::MODE_COLLECT && r_pos == 4'd0 && r_cnt == 32'd0)
        else $error("end of buffer did not restore the parse state");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 4'd7)
        else $error("field position ran past the last field");
    a_record_sep_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_rs && r_mode == drfs_pkg::MODE_COLLECT && !i_in.end_of_buffer |=>
        r_mode == drfs_pkg::MODE_SKIP && r_pos == 4'd0)
        else $error("record separator did not end the record");
`endif

endmodule

@@ rtl/core/drfs_queue.sv @@
// Small queue of result bundles between the front end and the back end.
module drfs_queue #(
    parameter int QUEUE_DEPTH = drfs_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  drfs_pkg::t_entry  i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output drfs_pkg::t_entry  o_head,
    output logic              o_empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    drfs_pkg::t_entry r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;
    logic w_push;
    logic w_pop;

    assign o_full = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/core/drfs_back.sv @@
// Back end: walks the results of each queued bundle into the output register.
module drfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  drfs_pkg::t_entry  i_head,
    output logic              o_pop,
    drfs_out_if.source        o_out
);

    logic [1:0]  r_slot;
    logic [1:0]  n_slot;
    logic        r_valid;
    logic        n_valid;
    logic [1:0]  r_kind;
    logic [1:0]  n_kind;
    logic [7:0]  r_target;
    logic [7:0]  n_target;
    logic [7:0]  r_byte;
    logic [7:0]  n_byte;
    logic [31:0] r_line;
    logic [31:0] n_line;
    logic [3:0]  r_seen;
    logic [3:0]  n_seen;
    logic        r_last;
    logic        n_last;

    logic w_load;
    logic w_last;
    drfs_pkg::t_slot w_cur;

    assign w_load = !i_empty && (!r_valid || o_out.ready);
    assign w_last = (r_slot == i_head.last);
    assign o_pop = w_load && w_last;
    assign w_cur = i_head.slots[r_slot];

    always_comb begin
        n_slot = r_slot;
        n_valid = r_valid;
        n_kind = r_kind;
        n_target = r_target;
        n_byte = r_byte;
        n_line = r_line;
        n_seen = r_seen;
        n_last = r_last;
        if (w_load) begin
            n_slot = w_last ? 2'd0 : r_slot + 2'd1;
            n_valid = 1'b1;
            n_kind = w_cur.kind;
            n_target = w_cur.target;
            n_byte = (w_cur.kind == drfs_pkg::KIND_FIELD_BYTE) ? i_head.data_byte : 8'd0;
            n_line = (w_cur.kind == drfs_pkg::KIND_RECORD_END) ? i_head.line : 32'd0;
            n_seen = (w_cur.kind == drfs_pkg::KIND_RECORD_END) ? i_head.seen : 4'd0;
            n_last = w_last;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_target <= n_target;
        r_byte <= n_byte;
        r_line <= n_line;
        r_seen <= n_seen;
        r_last <= n_last;
    end

    assign o_out.valid = r_valid;
    assign o_out.result_kind = r_kind;
    assign o_out.target_index = r_target;
    assign o_out.field_byte = r_byte;
    assign o_out.line_number = r_line;
    assign o_out.fields_seen = r_seen;
    assign o_out.last_of_run = r_last;

`ifndef SYNTHESIS
    a_slot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> r_slot == 2'd0)
        else $error("result index left nonzero with an empty queue");
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_slot <= i_head.last)
        else $error("result index ran past the bundle");
    a_record_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.result_kind == drfs_pkg::KIND_RECORD_END |-> o_out.last_of_run)
        else $error("record end was not the final result of its byte");
`endif

endmodule

@@ rtl/core/delimited_record_field_splitter_top.sv @@
// Top level of the delimited record field splitter.
// The block takes one text byte per cycle whenever its internal queue of QUEUE_DEPTH
// bundles has room, and classifies it against the field and record separator sets in
// that same cycle. Every byte yields zero to three results, which leave through a
// registered output one per cycle while the output is ready, so a byte that yields k
// results holds the output for all k of them; bytes with one result or none sustain one
// byte per cycle under the same condition. The output side is therefore what sets the
// throughput, with the queue absorbing short bursts of multi-result bytes such as
// separators at the end of a buffer. Configuration writes are always accepted and take
// effect at once; they should be made while no transaction is in flight.
module delimited_record_field_splitter_top #(
    parameter int QUEUE_DEPTH = drfs_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drfs_in_if.sink    i_in,
    drfs_cfg_if.sink   i_cfg,
    drfs_out_if.source o_out
);

    logic             w_push;
    drfs_pkg::t_entry w_push_data;
    logic             w_full;
    logic             w_pop;
    drfs_pkg::t_entry w_head;
    logic             w_empty;

    drfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    drfs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_empty     (w_empty)
    );

    drfs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the record field splitter: directed and random byte streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_BYTES = 34;
    localparam int CALM_PHASE = 5;
    localparam int MAX_REPORTS = 30;

    typedef struct {
        logic [7:0] data;
        logic       eob;
    } t_text_byte;

    typedef struct {
        drfs_pkg::t_kind kind;
        logic [7:0]  target;
        logic [7:0]  data;
        logic [31:0] line;
        logic [3:0]  seen;
        logic        last;
    } t_split_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    drfs_in_if  in_if ();
    drfs_out_if out_if ();
    drfs_cfg_if cfg_if ();

    delimited_record_field_splitter_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    logic [31:0] fsep_chars = 32'd44;
    logic [2:0]  fsep_count = 3'd1;
    logic [31:0] rsep_chars = 32'd10;
    logic [2:0]  rsep_count = 3'd1;
    logic [3:0]  field_count = 4'd1;
    logic [63:0] target_map = '1;

    drfs_pkg::t_mode parse_mode = drfs_pkg::MODE_COLLECT;
    logic [3:0]  field_pos = '0;
    logic [31:0] record_count = '0;

    t_text_byte    text_q[$];
    t_split_result split_results_q[$];

    int errors = 0;
    int bytes_in = 0;
    int results_out = 0;
    int records_out = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit in_sep_set(input logic [7:0] b, input logic [31:0] chars,
                                      input logic [2:0] count);
        int lim;
        bit hit;
        lim = (count > 3'(drfs_pkg::MAX_SEP_CHARS)) ? drfs_pkg::MAX_SEP_CHARS : int'(count);
        hit = 1'b0;
        for (int k = 0; k < lim; k++) begin
            if (chars[8*k +: 8] == b) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [3:0] fields_per_record();
        logic [3:0] n;
        n = field_count;
        if (n == 4'd0) begin
            n = 4'd1;
        end
        if (n > 4'(drfs_pkg::MAX_FIELDS)) begin
            n = 4'(drfs_pkg::MAX_FIELDS);
        end
        return n;
    endfunction

    function automatic void push_result(input drfs_pkg::t_kind kind, input logic [7:0] target,
                                        input logic [7:0] data, input logic [31:0] line,
                                        input logic [3:0] seen);
        t_split_result r;
        r.kind = kind;
        r.target = target;
        r.data = data;
        r.line = line;
        r.seen = seen;
        r.last = 1'b0;
        split_results_q.push_back(r);
    endfunction

    function automatic void close_field();
        logic [7:0] t;
        t = target_map[8*field_pos[2:0] +: 8];
        if (t != drfs_pkg::DISCARD_TARGET) begin
            push_result(drfs_pkg::KIND_FIELD_END, t, 8'd0, 32'd0, 4'd0);
        end
        field_pos = field_pos + 4'd1;
    endfunction

    function automatic void end_record();
        record_count = record_count + 32'd1;
        push_result(drfs_pkg::KIND_RECORD_END, 8'd0, 8'd0, record_count, field_pos);
        field_pos = '0;
    endfunction

    function automatic void split_byte(input logic [7:0] b, input logic eob);
        bit fs;
        bit rs;
        bit collect;
        int first;
        logic [7:0] t;
        first = split_results_q.size();
        fs = in_sep_set(b, fsep_chars, fsep_count);
        rs = !fs && in_sep_set(b, rsep_chars, rsep_count);
        collect = 1'b0;
        case (parse_mode)
            drfs_pkg::MODE_SKIP: begin
                if (!rs) begin
                    parse_mode = drfs_pkg::MODE_COLLECT;
                    collect = 1'b1;
                end
            end
            drfs_pkg::MODE_DROP: begin
                if (rs) begin
                    parse_mode = drfs_pkg::MODE_SKIP;
                end
            end
            default: begin
                parse_mode = drfs_pkg::MODE_COLLECT;
                collect = 1'b1;
            end
        endcase
        if (collect) begin
            if (fs) begin
                close_field();
                if (field_pos >= fields_per_record()) begin
                    end_record();
                    parse_mode = drfs_pkg::MODE_DROP;
                end
            end else if (rs) begin
                close_field();
                end_record();
                parse_mode = drfs_pkg::MODE_SKIP;
            end else begin
                t = target_map[8*field_pos[2:0] +: 8];
                if (t != drfs_pkg::DISCARD_TARGET) begin
                    push_result(drfs_pkg::KIND_FIELD_BYTE, t, b, 32'd0, 4'd0);
                end
            end
        end
        if (eob) begin
            if (parse_mode == drfs_pkg::MODE_COLLECT) begin
                close_field();
                end_record();
            end
            parse_mode = drfs_pkg::MODE_COLLECT;
            field_pos = '0;
            record_count = '0;
        end
        if (split_results_q.size() > first) begin
            split_results_q[split_results_q.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] val);
        case (idx)
            drfs_pkg::CFG_FIELD_SEP_CHARS: fsep_chars = val[31:0];
            drfs_pkg::CFG_FIELD_SEP_COUNT: fsep_count = val[2:0];
            drfs_pkg::CFG_RECORD_SEP_CHARS: rsep_chars = val[31:0];
            drfs_pkg::CFG_RECORD_SEP_COUNT: rsep_count = val[2:0];
            drfs_pkg::CFG_DEFINED_FIELD_COUNT: field_count = val[3:0];
            drfs_pkg::CFG_FIELD_TARGET_MAP: target_map = val;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Leaves valid high so that back-to-back writes follow without valid dropping between them.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic write_config(input logic [31:0] fc, input logic [2:0] fn,
                                input logic [31:0] rc, input logic [2:0] rn,
                                input logic [3:0] nf, input logic [63:0] map);
        write_reg(drfs_pkg::CFG_FIELD_SEP_CHARS, {$urandom, fc});
        write_reg(drfs_pkg::CFG_FIELD_SEP_COUNT, {$urandom, 29'($urandom), fn});
        write_reg(drfs_pkg::CFG_RECORD_SEP_CHARS, {$urandom, rc});
        write_reg(drfs_pkg::CFG_RECORD_SEP_COUNT, {$urandom, 29'($urandom), rn});
        write_reg(drfs_pkg::CFG_DEFINED_FIELD_COUNT, {$urandom, 28'($urandom), nf});
        write_reg(drfs_pkg::CFG_FIELD_TARGET_MAP, map);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        while (text_q.size() != 0 || in_if.valid || split_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_byte(input logic [7:0] data, input logic eob);
        t_text_byte tb;
        tb.data = data;
        tb.eob = eob;
        text_q.push_back(tb);
    endfunction

    function automatic logic [7:0] pick_sep(input logic [31:0] chars, input logic [2:0] count);
        int lim;
        if (count == 3'd0) begin
            return 8'($urandom_range(0, 255));
        end
        lim = (count > 3'(drfs_pkg::MAX_SEP_CHARS)) ? drfs_pkg::MAX_SEP_CHARS : int'(count);
        return chars[8*$urandom_range(0, lim - 1) +: 8];
    endfunction

    function automatic logic [31:0] rand_chars();
        logic [31:0] c;
        for (int k = 0; k < drfs_pkg::MAX_SEP_CHARS; k++) begin
            c[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [63:0] rand_map();
        logic [63:0] m;
        for (int k = 0; k < drfs_pkg::MAX_FIELDS; k++) begin
            m[8*k +: 8] = ($urandom_range(0, 3) == 0) ? drfs_pkg::DISCARD_TARGET
                                                      : 8'($urandom_range(0, 255));
        end
        return m;
    endfunction

    // Mostly whole records with random content; the rest is noise and cut-off records.
    function automatic void gen_traffic(input int n);
        int added;
        int nf;
        int len;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 99) < 12) begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
                added++;
            end else begin
                nf = $urandom_range(1, int'(fields_per_record()) + 1);
                for (int f = 0; f < nf; f++) begin
                    len = $urandom_range(0, 4);
                    repeat (len) push_byte(8'($urandom_range(0, 255)), 1'b0);
                    added += len;
                    if (f < nf - 1) begin
                        push_byte(pick_sep(fsep_chars, fsep_count), 1'b0);
                        added++;
                    end
                end
                case ($urandom_range(0, 7))
                    0: begin
                        push_byte(pick_sep(rsep_chars, rsep_count), 1'b1);
                        added++;
                    end
                    1: begin
                        len = $urandom_range(2, 4);
                        repeat (len) push_byte(pick_sep(rsep_chars, rsep_count), 1'b0);
                        added += len;
                    end
                    2: ;
                    3: begin
                        push_byte(8'($urandom_range(0, 255)), 1'b1);
                        added++;
                    end
                    default: begin
                        push_byte(pick_sep(rsep_chars, rsep_count), 1'b0);
                        added++;
                    end
                endcase
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_byte nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                split_byte(in_if.data_byte, in_if.end_of_buffer);
                bytes_in++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
                    nxt = text_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.data_byte <= nxt.data;
                    in_if.end_of_buffer <= nxt.eob;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_split_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_out++;
                if (split_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result of kind %0d",
                                              out_if.result_kind));
                end else begin
                    want = split_results_q.pop_front();
                    if (want.kind == drfs_pkg::KIND_RECORD_END) begin
                        records_out++;
                    end
                    if (out_if.result_kind !== want.kind) begin
                        report_mismatch($sformatf("result_kind %0d, want %0d",
                                                  out_if.result_kind, want.kind));
                    end
                    if (out_if.target_index !== want.target) begin
                        report_mismatch($sformatf("target_index %0d, want %0d",
                                                  out_if.target_index, want.target));
                    end
                    if (out_if.field_byte !== want.data) begin
                        report_mismatch($sformatf("field_byte %h, want %h",
                                                  out_if.field_byte, want.data));
                    end
                    if (out_if.line_number !== want.line) begin
                        report_mismatch($sformatf("line_number %0d, want %0d",
                                                  out_if.line_number, want.line));
                    end
                    if (out_if.fields_seen !== want.seen) begin
                        report_mismatch($sformatf("fields_seen %0d, want %0d",
                                                  out_if.fields_seen, want.seen));
                    end
                    if (out_if.last_of_run !== want.last) begin
                        report_mismatch($sformatf("last_of_run %0d, want %0d",
                                                  out_if.last_of_run, want.last));
                    end
                end
            end
            out_if.ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.end_of_buffer = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_byte(8'h0A, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h2C, 1'b1);
        settle();

        write_config(32'h7C00_3B2C, 3'd3, 32'h2C7C_0D0A, 3'd7, 4'd3,
                     64'h1111_1111_1100_FF05);
        push_byte(8'h0A, 1'b0);
        push_byte(8'h0D, 1'b0);
        push_byte(8'h7C, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h3B, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h2C, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h2C, 1'b0);
        push_byte(8'h0A, 1'b0);
        push_byte(8'h0A, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'h0D, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h43, 1'b1);
        push_byte(8'h2C, 1'b1);
        push_byte(8'h0A, 1'b1);
        push_byte(8'h61, 1'b0);
        push_byte(8'h3B, 1'b0);
        settle();

        // The field count drops below the open field while a record is in progress.
        write_reg(drfs_pkg::CFG_DEFINED_FIELD_COUNT, 64'd0);
        cfg_if.valid <= 1'b0;
        push_byte(8'h2C, 1'b0);
        push_byte(8'h0A, 1'b1);
        settle();

        for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
            case (ph)
                1: write_config(32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd4, 4'd15, 64'd0);
                2: write_config(rand_chars(), 3'd0, rand_chars(), 3'd7, 4'd0, '1);
                3: write_config(rand_chars(), 3'd4, rand_chars(), 3'd0, 4'd8,
                                64'hFEFE_FEFE_FEFE_FEFE);
                default: write_config(rand_chars(), 3'($urandom_range(0, 7)), rand_chars(),
                                      3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                      rand_map());
            endcase
            calm = (ph == CALM_PHASE);
            gen_traffic(PHASE_BYTES);
            settle();
        end
        calm = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (split_results_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", split_results_q.size()));
        end
        $display("Sent %0d bytes under %0d register writes; checked %0d results (%0d records).",
                 bytes_in, cfg_writes, results_out, records_out);
        $display("Covered directed separator cases and %0d random separator settings.",
                 RANDOM_PHASES);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/drfs_pkg.sv
rtl/core/drfs_if.sv
rtl/core/drfs_front.sv
rtl/core/drfs_queue.sv
rtl/core/drfs_back.sv
rtl/core/delimited_record_field_splitter_top.sv
dv/tb_top.sv
